// ===== rtl/core/sdik_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared constants, types and angle table of the swerve kinematics core
package sdik_pkg;

  // format constants
  localparam int STEER_CODE_BITS = 12;
  localparam int CMD_FRAC_BITS   = 14;

  localparam int CordicSteps = 20;
  localparam int GuardBits   = 12;

  // field and datapath widths
  localparam int RegW    = 12;
  localparam int CfgIdxW = 3;
  localparam int CmdW    = 16;
  localparam int YawW    = 16;
  localparam int SteerW  = 12;
  localparam int SpeedW  = 15;
  localparam int FactW   = 16;
  localparam int TermW   = 20;
  localparam int RotW    = 32;
  localparam int VecW    = TermW + GuardBits;
  localparam int DistW   = 17;
  localparam int Wheels  = 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_WHEELBASE = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_TRACK     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_OFF_FL    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_OFF_FR    = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] REG_OFF_RL    = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] REG_OFF_RR    = CfgIdxW'(5);

  // geometry handed to the datapath
  typedef struct packed {
    logic [FactW-1:0]             kl;
    logic [FactW-1:0]             kw;
    logic [Wheels-1:0][RegW-1:0]  offset;
  } geom_t;

  // the four corner terms
  typedef struct packed {
    logic signed [TermW-1:0] a;
    logic signed [TermW-1:0] b;
    logic signed [TermW-1:0] c;
    logic signed [TermW-1:0] d;
  } corner_t;

  // arctangent of 2^-i as a 32-bit turn angle
  function automatic logic [31:0] arc_angle(input int idx);
    logic [31:0] r;
    case (idx)
      0:       r = 32'd536870912;
      1:       r = 32'd316933406;
      2:       r = 32'd167458907;
      3:       r = 32'd85004756;
      4:       r = 32'd42667331;
      5:       r = 32'd21354465;
      6:       r = 32'd10679838;
      7:       r = 32'd5340245;
      8:       r = 32'd2670163;
      9:       r = 32'd1335087;
      10:      r = 32'd667544;
      11:      r = 32'd333772;
      12:      r = 32'd166886;
      13:      r = 32'd83443;
      14:      r = 32'd41722;
      15:      r = 32'd20861;
      16:      r = 32'd10430;
      17:      r = 32'd5215;
      18:      r = 32'd2608;
      19:      r = 32'd1304;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sdik_geom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// configuration registers and sequential twist factor unit
module sdik_geom (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sdik_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sdik_pkg::RegW-1:0]    cfg_data_i,
  output sdik_pkg::geom_t              geom_o,
  output logic                         busy_o
);
  import sdik_pkg::*;

  localparam int R2W   = 2 * RegW + 1;
  localparam int SqW   = R2W + 30;
  localparam int RootW = (SqW + 1) / 2;
  localparam int NumW  = RegW + 30 + 1;
  localparam int CntW  = $clog2(NumW + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_START, ST_SQRT, ST_DIV_L, ST_DIV_W} state_e;

  logic                        cfg_we;
  logic                        geo_wr;
  logic [RegW-1:0]             len_q, wid_q;
  logic [Wheels-1:0][RegW-1:0] off_q;
  logic [R2W-1:0]              r2;
  state_e                      state_q;
  logic [SqW-1:0]              v_q, res_q, bit_q, trial;
  logic [RootW-1:0]            root;
  logic [NumW-1:0]             num_q;
  logic [RootW-1:0]            rem_q, rem_n;
  logic [RootW:0]              div_t;
  logic                        ge;
  logic [FactW-1:0]            quo_q, quo_n, kl_q, kw_q;
  logic [CntW-1:0]             cnt_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign geo_wr      = cfg_we && (cfg_index_i == REG_WHEELBASE || cfg_index_i == REG_TRACK);

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= RegW'(1000);
      wid_q <= RegW'(1000);
      off_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_WHEELBASE: len_q    <= cfg_data_i;
        REG_TRACK:     wid_q    <= cfg_data_i;
        REG_OFF_FL:    off_q[0] <= cfg_data_i;
        REG_OFF_FR:    off_q[1] <= cfg_data_i;
        REG_OFF_RL:    off_q[2] <= cfg_data_i;
        REG_OFF_RR:    off_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // squared diagonal
  assign r2 = R2W'(len_q) * R2W'(len_q) + R2W'(wid_q) * R2W'(wid_q);

  // sqrt trial and long division step
  always_comb begin
    trial = res_q + bit_q;
    root  = res_q[RootW-1:0];
    div_t = {rem_q, num_q[NumW-1]};
    ge    = div_t >= {1'b0, root};
    rem_n = ge ? RootW'(div_t - {1'b0, root}) : div_t[RootW-1:0];
    quo_n = {quo_q[FactW-2:0], ge};
  end

  // factor sequencer: isqrt, then two divisions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      v_q     <= '0;
      res_q   <= '0;
      bit_q   <= '0;
      num_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      kl_q    <= '0;
      kw_q    <= '0;
    end else if (geo_wr) begin
      state_q <= ST_START;
    end else begin
      case (state_q)
        ST_IDLE: ;
        ST_START: begin
          if (r2 == '0) begin
            kl_q    <= '0;
            kw_q    <= '0;
            state_q <= ST_IDLE;
          end else begin
            v_q     <= {r2, 30'd0};
            res_q   <= '0;
            bit_q   <= SqW'(1) << (SqW - 1);
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (bit_q == '0) begin
            num_q   <= NumW'({len_q, 30'd0}) + NumW'(root >> 1);
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= CntW'(NumW);
            state_q <= ST_DIV_L;
          end else begin
            if (v_q >= trial) begin
              v_q   <= v_q - trial;
              res_q <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        ST_DIV_L: begin
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            kl_q    <= quo_n;
            num_q   <= NumW'({wid_q, 30'd0}) + NumW'(root >> 1);
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= CntW'(NumW);
            state_q <= ST_DIV_W;
          end else begin
            num_q <= num_q << 1;
            rem_q <= rem_n;
            quo_q <= quo_n;
          end
        end
        ST_DIV_W: begin
          cnt_q <= cnt_q - CntW'(1);
          num_q <= num_q << 1;
          rem_q <= rem_n;
          quo_q <= quo_n;
          if (cnt_q == CntW'(1)) begin
            kw_q    <= quo_n;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o        = state_q != ST_IDLE;
  assign geom_o.kl     = kl_q;
  assign geom_o.kw     = kw_q;
  assign geom_o.offset = off_q;

endmodule
`default_nettype wire

// ===== rtl/core/sdik_rotate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// yaw rotation pipeline and twist mixing into corner terms
module sdik_rotate (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             valid_i,
  input  logic signed [sdik_pkg::CmdW-1:0] forward_i,
  input  logic signed [sdik_pkg::CmdW-1:0] strafe_i,
  input  logic signed [sdik_pkg::CmdW-1:0] twist_i,
  input  logic                             field_rel_i,
  input  logic [sdik_pkg::YawW-1:0]        yaw_i,
  input  logic [sdik_pkg::FactW-1:0]       kl_i,
  input  logic [sdik_pkg::FactW-1:0]       kw_i,
  output logic                             valid_o,
  output sdik_pkg::corner_t                corner_o
);
  import sdik_pkg::*;

  localparam int Steps  = CordicSteps;
  localparam int Depth  = Steps + 4;
  localparam int ProdW  = CmdW + RotW;
  localparam int SumW   = ProdW + 1;
  localparam int RotTW  = SumW - 30;
  localparam int TwPW   = CmdW + FactW + 1;
  localparam int TlW    = TwPW + 1 - 15;
  localparam logic signed [RotW-1:0] RotGain  = RotW'(652032874);
  localparam logic signed [SumW-1:0] RoundQ30 = SumW'(64'd1 << 29);
  localparam logic signed [TwPW:0]   RoundQ15 = (TwPW + 1)'(64'd1 << 14);

  logic [Depth-1:0]        vld_q;
  logic [31:0]             ang, ang_f;
  logic                    flip;

  logic signed [RotW-1:0]  x_q   [0:Steps];
  logic signed [RotW-1:0]  y_q   [0:Steps];
  logic signed [RotW-1:0]  z_q   [0:Steps];
  logic                    flip_q[0:Steps];
  logic                    rel_q [0:Steps];
  logic signed [CmdW-1:0]  fwd_q [0:Steps];
  logic signed [CmdW-1:0]  str_q [0:Steps];
  logic signed [CmdW-1:0]  tw_q  [0:Steps];

  logic signed [RotW-1:0]  sin_v, cos_v;
  logic signed [ProdW-1:0] fs_q, sc_q, fc_q, ss_q;
  logic signed [TwPW-1:0]  tkl_p_q, tkw_p_q, tkl_s_q, tkw_s_q;
  logic signed [CmdW-1:0]  fwd_p_q, str_p_q;
  logic                    rel_p_q;

  logic signed [SumW-1:0]  nf_sum, ns_sum;
  logic signed [TermW-1:0] fwd_d, str_d, fwd_s_q, str_s_q;
  logic signed [TwPW:0]    tl_sum, tt_sum;
  logic signed [TermW-1:0] tl, tt;
  corner_t                 corner_q;

  // quadrant fold of the yaw angle
  always_comb begin
    ang   = {yaw_i, 16'h0000};
    flip  = ang[31] ^ ang[30];
    ang_f = flip ? {~ang[31], ang[30:0]} : ang;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  // input capture and cordic seed
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]    <= RotGain;
      y_q[0]    <= '0;
      z_q[0]    <= $signed(ang_f);
      flip_q[0] <= flip;
      rel_q[0]  <= field_rel_i;
      fwd_q[0]  <= forward_i;
      str_q[0]  <= strafe_i;
      tw_q[0]   <= twist_i;
    end
  end

  // rotation cordic, one step per stage
  for (genvar i = 0; i < Steps; i++) begin : g_rot
    localparam logic signed [RotW-1:0] Arc = $signed(RotW'(arc_angle(i)));
    logic signed [RotW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (!z_q[i][RotW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - Arc;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + Arc;
        end
        flip_q[i+1] <= flip_q[i];
        rel_q[i+1]  <= rel_q[i];
        fwd_q[i+1]  <= fwd_q[i];
        str_q[i+1]  <= str_q[i];
        tw_q[i+1]   <= tw_q[i];
      end
    end
  end

  // unfold sin and cos
  assign sin_v = flip_q[Steps] ? -y_q[Steps] : y_q[Steps];
  assign cos_v = flip_q[Steps] ? -x_q[Steps] : x_q[Steps];

  // product stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fs_q    <= fwd_q[Steps] * sin_v;
      sc_q    <= str_q[Steps] * cos_v;
      fc_q    <= fwd_q[Steps] * cos_v;
      ss_q    <= str_q[Steps] * sin_v;
      tkl_p_q <= tw_q[Steps] * $signed({1'b0, kl_i});
      tkw_p_q <= tw_q[Steps] * $signed({1'b0, kw_i});
      fwd_p_q <= fwd_q[Steps];
      str_p_q <= str_q[Steps];
      rel_p_q <= rel_q[Steps];
    end
  end

  // rounded sums of the rotated commands
  always_comb begin
    nf_sum = {fs_q[ProdW-1], fs_q} + {sc_q[ProdW-1], sc_q} + RoundQ30;
    ns_sum = {ss_q[ProdW-1], ss_q} - {fc_q[ProdW-1], fc_q} + RoundQ30;
    fwd_d  = rel_p_q ? {{(TermW-RotTW){nf_sum[SumW-1]}}, nf_sum[SumW-1:30]}
                     : {{(TermW-CmdW){fwd_p_q[CmdW-1]}}, fwd_p_q};
    str_d  = rel_p_q ? {{(TermW-RotTW){ns_sum[SumW-1]}}, ns_sum[SumW-1:30]}
                     : {{(TermW-CmdW){str_p_q[CmdW-1]}}, str_p_q};
  end

  // sum stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fwd_s_q <= fwd_d;
      str_s_q <= str_d;
      tkl_s_q <= tkl_p_q;
      tkw_s_q <= tkw_p_q;
    end
  end

  // twist terms and corners
  always_comb begin
    tl_sum = {tkl_s_q[TwPW-1], tkl_s_q} + RoundQ15;
    tt_sum = {tkw_s_q[TwPW-1], tkw_s_q} + RoundQ15;
    tl     = {{(TermW-TlW){tl_sum[TwPW]}}, tl_sum[TwPW:15]};
    tt     = {{(TermW-TlW){tt_sum[TwPW]}}, tt_sum[TwPW:15]};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      corner_q.a <= str_s_q + tl;
      corner_q.b <= str_s_q - tl;
      corner_q.c <= fwd_s_q + tt;
      corner_q.d <= fwd_s_q - tt;
    end
  end

  assign valid_o  = vld_q[Depth-1];
  assign corner_o = corner_q;

endmodule
`default_nettype wire

// ===== rtl/core/sdik_vector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// per wheel vectoring pipeline: steering angle and wheel speed
module sdik_vector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  logic signed [sdik_pkg::TermW-1:0] py_i,
  input  logic signed [sdik_pkg::TermW-1:0] px_i,
  input  logic [sdik_pkg::RegW-1:0]         offset_i,
  output logic                              valid_o,
  output logic [sdik_pkg::SteerW-1:0]       steer_o,
  output logic [sdik_pkg::DistW-1:0]        dist_o
);
  import sdik_pkg::*;

  localparam int Steps  = CordicSteps;
  localparam int Depth  = Steps + 3;
  localparam int SB     = STEER_CODE_BITS;
  localparam int ProdW  = VecW - 1 + 32;
  localparam int MagSh  = 32 + GuardBits;
  localparam int OffSW  = (SB > RegW) ? SB : RegW;
  localparam logic [31:0]    MagGain  = 32'd2608131497;
  localparam logic [ProdW:0] MagRound = (ProdW + 1)'(64'd1 << (MagSh - 1));
  localparam logic [32:0]    CodeRnd  = 33'(64'd1 << (31 - SB));

  logic [Depth-1:0]       vld_q;
  logic signed [VecW-1:0] x0, y0;
  logic signed [VecW-1:0] x_q [0:Steps];
  logic signed [VecW-1:0] y_q [0:Steps];
  logic [31:0]            z_q [0:Steps];
  logic                   nz_q[0:Steps];

  logic [VecW-2:0]        xc;
  logic [ProdW-1:0]       prod_q;
  logic [31:0]            z_m_q;
  logic                   nz_m_q;
  logic [ProdW:0]         msum;
  logic [31:0]            u;
  logic [32:0]            code_full;
  logic [SB-1:0]          code;
  logic [OffSW-1:0]       off_sum;
  logic [SteerW-1:0]      steer_q;
  logic [DistW-1:0]       dist_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  // scaled inputs
  assign x0 = {px_i, {GuardBits{1'b0}}};
  assign y0 = {py_i, {GuardBits{1'b0}}};

  // seed, folding the left half plane
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (x0[VecW-1]) begin
        x_q[0] <= -x0;
        y_q[0] <= -y0;
        z_q[0] <= 32'h8000_0000;
      end else begin
        x_q[0] <= x0;
        y_q[0] <= y0;
        z_q[0] <= 32'h0;
      end
      nz_q[0] <= (px_i != '0) || (py_i != '0);
    end
  end

  // vectoring cordic, one step per stage
  for (genvar i = 0; i < Steps; i++) begin : g_vec
    localparam logic [31:0] Arc = arc_angle(i);
    logic signed [VecW-1:0] dx, dy;
    logic                   pos;
    assign dx  = y_q[i] >>> i;
    assign dy  = x_q[i] >>> i;
    assign pos = !y_q[i][VecW-1] && (y_q[i] != '0);
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (pos) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + Arc;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - Arc;
        end
        nz_q[i+1] <= nz_q[i];
      end
    end
  end

  // gain removal multiply
  assign xc = x_q[Steps][VecW-1] ? '0 : x_q[Steps][VecW-2:0];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= xc * MagGain;
      z_m_q  <= z_q[Steps];
      nz_m_q <= nz_q[Steps];
    end
  end

  // magnitude rounding and steering code
  always_comb begin
    msum      = {1'b0, prod_q} + MagRound;
    u         = 32'h8000_0000 - z_m_q;
    code_full = {1'b0, u} + CodeRnd;
    code      = nz_m_q ? code_full[32-SB +: SB] : '0;
    off_sum   = OffSW'(code) + OffSW'(offset_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dist_q  <= msum[MagSh +: DistW];
      steer_q <= SteerW'(off_sum[SB-1:0]);
    end
  end

  assign valid_o = vld_q[Depth-1];
  assign steer_o = steer_q;
  assign dist_o  = dist_q;

endmodule
`default_nettype wire

// ===== rtl/core/sdik_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// speed normalization: max search and pipelined dividers, output register
module sdik_norm (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  adv_i,
  input  logic                                                  valid_i,
  input  logic [sdik_pkg::Wheels-1:0][sdik_pkg::DistW-1:0]      dist_i,
  input  logic [sdik_pkg::Wheels-1:0][sdik_pkg::SteerW-1:0]     steer_i,
  output logic                                                  valid_o,
  output logic [sdik_pkg::Wheels-1:0][sdik_pkg::SteerW-1:0]     steer_o,
  output logic [sdik_pkg::Wheels-1:0][sdik_pkg::SpeedW-1:0]     speed_o
);
  import sdik_pkg::*;

  localparam int CF    = CMD_FRAC_BITS;
  localparam int QW    = CF + 1;
  localparam int NumW  = DistW + CF + 1;
  localparam int Depth = QW + 3;
  localparam logic [DistW:0] One = (DistW + 1)'(64'd1 << CF);

  typedef logic [Wheels-1:0][DistW-1:0]  dist_v_t;
  typedef logic [Wheels-1:0][SteerW-1:0] steer_v_t;
  typedef logic [Wheels-1:0][QW-1:0]     quo_v_t;

  logic [Depth-1:0]  vld_q;
  logic [DistW-1:0]  m01_q, m23_q, maxd;
  dist_v_t           d1_q;
  steer_v_t          s1_q;

  dist_v_t           rem_q [0:QW];
  quo_v_t            low_q [0:QW];
  quo_v_t            quo_q [0:QW];
  dist_v_t           dst_q [0:QW];
  steer_v_t          str_q [0:QW];
  logic [DistW-1:0]  max_q [0:QW];
  logic              big_q [0:QW];

  logic [Wheels-1:0][NumW-1:0] num;
  steer_v_t                    steer_q;
  logic [Wheels-1:0][SpeedW-1:0] speed_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  // first level of the max tree
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m01_q <= (dist_i[1] > dist_i[0]) ? dist_i[1] : dist_i[0];
      m23_q <= (dist_i[3] > dist_i[2]) ? dist_i[3] : dist_i[2];
      d1_q  <= dist_i;
      s1_q  <= steer_i;
    end
  end

  // largest speed and rounded numerators
  assign maxd = (m23_q > m01_q) ? m23_q : m01_q;

  for (genvar w = 0; w < Wheels; w++) begin : g_num
    assign num[w] = {1'b0, d1_q[w], {CF{1'b0}}} + NumW'(maxd >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int w = 0; w < Wheels; w++) begin
        rem_q[0][w] <= num[w][NumW-1:QW];
        low_q[0][w] <= num[w][QW-1:0];
      end
      quo_q[0] <= '0;
      dst_q[0] <= d1_q;
      str_q[0] <= s1_q;
      max_q[0] <= maxd;
      big_q[0] <= {1'b0, maxd} > One;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [Wheels-1:0][DistW:0]   t;
    logic [Wheels-1:0]            ge;
    for (genvar w = 0; w < Wheels; w++) begin : g_lane
      assign t[w]  = {rem_q[k][w], low_q[k][w][QW-1]};
      assign ge[w] = t[w] >= {1'b0, max_q[k]};
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        for (int w = 0; w < Wheels; w++) begin
          rem_q[k+1][w] <= ge[w] ? DistW'(t[w] - {1'b0, max_q[k]}) : t[w][DistW-1:0];
          low_q[k+1][w] <= low_q[k][w] << 1;
          quo_q[k+1][w] <= {quo_q[k][w][QW-2:0], ge[w]};
        end
        dst_q[k+1] <= dst_q[k];
        str_q[k+1] <= str_q[k];
        max_q[k+1] <= max_q[k];
        big_q[k+1] <= big_q[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int w = 0; w < Wheels; w++) begin
        speed_q[w] <= big_q[QW] ? SpeedW'(quo_q[QW][w]) : SpeedW'(dst_q[QW][w]);
      end
      steer_q <= str_q[QW];
    end
  end

  assign valid_o = vld_q[Depth-1];
  assign steer_o = steer_q;
  assign speed_o = speed_q;

endmodule
`default_nettype wire

// ===== rtl/core/swerve_drive_inverse_kinematics.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One word per cycle when the output is not held and the factor unit is idle.
// A whole-pipe stall holds every stage while a result waits at the output register.
// Reset clears all valid bits; the twist factors are recomputed by a sequential
// sqrt and divide unit after reset or after a write to the wheelbase or track
// register, and no input word is taken while that unit is busy.
module swerve_drive_inverse_kinematics (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [sdik_pkg::CmdW-1:0] forward_cmd_i,
  input  logic signed [sdik_pkg::CmdW-1:0] strafe_cmd_i,
  input  logic signed [sdik_pkg::CmdW-1:0] twist_cmd_i,
  input  logic                          field_relative_i,
  input  logic [sdik_pkg::YawW-1:0]     yaw_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sdik_pkg::SteerW-1:0]   steer_front_left_o,
  output logic [sdik_pkg::SteerW-1:0]   steer_front_right_o,
  output logic [sdik_pkg::SteerW-1:0]   steer_rear_left_o,
  output logic [sdik_pkg::SteerW-1:0]   steer_rear_right_o,
  output logic [sdik_pkg::SpeedW-1:0]   speed_front_left_o,
  output logic [sdik_pkg::SpeedW-1:0]   speed_front_right_o,
  output logic [sdik_pkg::SpeedW-1:0]   speed_rear_left_o,
  output logic [sdik_pkg::SpeedW-1:0]   speed_rear_right_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sdik_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sdik_pkg::RegW-1:0]     cfg_data_i
);
  import sdik_pkg::*;

  logic                            adv, busy, accept;
  geom_t                           geom;
  logic                            rot_valid, vec_valid;
  corner_t                         corner;
  logic [Wheels-1:0][DistW-1:0]    wheel_dist;
  logic [Wheels-1:0][SteerW-1:0]   steer, steer_out;
  logic [Wheels-1:0][SpeedW-1:0]   speed_out;

  // pipeline advances unless a result is held at the output
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv && !busy;
  assign accept     = in_valid_i && in_ready_o;

  sdik_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom),
    .busy_o      (busy)
  );

  sdik_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (accept),
    .forward_i   (forward_cmd_i),
    .strafe_i    (strafe_cmd_i),
    .twist_i     (twist_cmd_i),
    .field_rel_i (field_relative_i),
    .yaw_i       (yaw_angle_i),
    .kl_i        (geom.kl),
    .kw_i        (geom.kw),
    .valid_o     (rot_valid),
    .corner_o    (corner)
  );

  // front left: (b, d)
  sdik_vector u_vec_fl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (rot_valid),
    .py_i     (corner.b),
    .px_i     (corner.d),
    .offset_i (geom.offset[0]),
    .valid_o  (vec_valid),
    .steer_o  (steer[0]),
    .dist_o   (wheel_dist[0])
  );

  // front right: (b, c)
  sdik_vector u_vec_fr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (rot_valid),
    .py_i     (corner.b),
    .px_i     (corner.c),
    .offset_i (geom.offset[1]),
    .valid_o  (),
    .steer_o  (steer[1]),
    .dist_o   (wheel_dist[1])
  );

  // rear left: (a, d)
  sdik_vector u_vec_rl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (rot_valid),
    .py_i     (corner.a),
    .px_i     (corner.d),
    .offset_i (geom.offset[2]),
    .valid_o  (),
    .steer_o  (steer[2]),
    .dist_o   (wheel_dist[2])
  );

  // rear right: (a, c)
  sdik_vector u_vec_rr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (rot_valid),
    .py_i     (corner.a),
    .px_i     (corner.c),
    .offset_i (geom.offset[3]),
    .valid_o  (),
    .steer_o  (steer[3]),
    .dist_o   (wheel_dist[3])
  );

  sdik_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (vec_valid),
    .dist_i  (wheel_dist),
    .steer_i (steer),
    .valid_o (out_valid_o),
    .steer_o (steer_out),
    .speed_o (speed_out)
  );

  assign steer_front_left_o  = steer_out[0];
  assign steer_front_right_o = steer_out[1];
  assign steer_rear_left_o   = steer_out[2];
  assign steer_rear_right_o  = steer_out[3];
  assign speed_front_left_o  = speed_out[0];
  assign speed_front_right_o = speed_out[1];
  assign speed_rear_left_o   = speed_out[2];
  assign speed_rear_right_o  = speed_out[3];

endmodule
`default_nettype wire
